>>> rtl/tx26_pkg.sv
// ----------------------------------------------------------------------------
// tx26_pkg
// Shared constants and Hamming 24/18 helpers for the X/26 triplet decoder.
// ----------------------------------------------------------------------------
package tx26_pkg;

	localparam int unsigned RawW   = 24;
	localparam int unsigned DataW  = 18;
	localparam int unsigned SynW   = 7;
	localparam int unsigned RowW   = 5;
	localparam int unsigned ColW   = 6;
	localparam int unsigned CodeW  = 7;
	localparam int unsigned ModeW  = 5;
	localparam int unsigned DiacW  = 4;

	// triplet address split and special rows
	localparam logic [ColW-1:0] RowGroupFirst = 6'd40;
	localparam logic [RowW-1:0] LastRow       = 5'd24;

	// triplet mode codes
	localparam logic [ModeW-1:0] ModeSetActive = 5'h04;
	localparam logic [ModeW-1:0] ModeG2Char    = 5'h0F;
	localparam logic [ModeW-1:0] ModeDiacFirst = 5'h11;
	localparam logic [ModeW-1:0] ModeDiacLast  = 5'h1F;

	// lowest printable G2 code
	localparam logic [CodeW-1:0] G2CodeMin = 7'd32;

	// kinds of character write
	localparam logic KindG2   = 1'b0;
	localparam logic KindDiac = 1'b1;

	// syndrome: bit k (k < 23) contributes k + 33, bit 23 contributes 32
	function automatic logic [SynW-1:0] tx26_syndrome(input logic [RawW-1:0] word);
		logic [SynW-1:0] syn;
		syn = '0;
		for (int k = 0; k < RawW - 1; k++) begin
			if (word[k]) begin
				syn = syn ^ SynW'(k + 33);
			end
		end
		if (word[RawW-1]) begin
			syn = syn ^ SynW'(32);
		end
		return syn;
	endfunction

	// true when the triplet holds a double error
	function automatic logic tx26_uncorrectable(input logic [SynW-1:0] syn);
		return (syn[4:0] != 5'h1F) && syn[5];
	endfunction

	// flip the bit that the syndrome points at, then pack the data bits
	function automatic logic [DataW-1:0] tx26_extract(input logic [RawW-1:0] word,
			input logic [SynW-1:0] syn);
		logic [RawW-1:0] fixed;
		fixed = word;
		if (syn[4:0] != 5'h1F) begin
			for (int i = 0; i < RawW; i++) begin
				if (syn[4:0] == 5'(30 - i)) begin
					fixed[i] = ~word[i];
				end
			end
		end
		return {fixed[22:16], fixed[14:8], fixed[6:4], fixed[2]};
	endfunction

endpackage

>>> rtl/tx26_if.sv
// ----------------------------------------------------------------------------
// tx26 channel interfaces
// Valid/ready channels for incoming triplets and outgoing character writes.
// ----------------------------------------------------------------------------

// incoming raw triplets
interface tx26_trip_if;
	logic        valid;
	logic        ready;
	logic [23:0] triplet_raw;
	logic        packet_start;

	modport source (output valid, triplet_raw, packet_start, input ready);
	modport sink   (input valid, triplet_raw, packet_start, output ready);
endinterface

// outgoing character writes
interface tx26_char_if;
	logic       valid;
	logic       ready;
	logic [4:0] char_row;
	logic [5:0] char_column;
	logic [6:0] char_code;
	logic       char_kind;
	logic [3:0] diacritic;

	modport source (output valid, char_row, char_column, char_code, char_kind, diacritic,
		input ready);
	modport sink   (input valid, char_row, char_column, char_code, char_kind, diacritic,
		output ready);
endinterface

>>> rtl/teletext_x26_triplet_decoder_unit.sv
// ----------------------------------------------------------------------------
// teletext_x26_triplet_decoder_unit
// Hamming 24/18 correction of X/26 triplets, active row tracking and
// emission of G2 and diacritic character writes.
// ----------------------------------------------------------------------------
// path: an accepted triplet moves through the input register and then the
//   output register before its write is valid on the output
// throughput: one triplet per cycle (single decode stage) unless a write stalls
// reset: clears the input and output valid flags, the active row and the
//   stop flag; payload registers are not reset
module teletext_x26_triplet_decoder_unit
	import tx26_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	tx26_trip_if.sink          triplets,
	tx26_char_if.source        writes
);

	// input register
	logic               valid_s1;
	logic [RawW-1:0]    raw_s1;
	logic               start_s1;

	// decoder state
	logic [RowW-1:0]    active_row_q;
	logic               stopped_q;

	// output register
	logic               out_valid_q;
	logic [RowW-1:0]    char_row_q;
	logic [ColW-1:0]    char_column_q;
	logic [CodeW-1:0]   char_code_q;
	logic               char_kind_q;
	logic [DiacW-1:0]   diacritic_q;

	// decode results
	logic               has_result;
	logic [RowW-1:0]    row_next;
	logic               stopped_next;
	logic [ColW-1:0]    addr;
	logic [ModeW-1:0]   mode;
	logic [CodeW-1:0]   code;
	logic               out_adv;
	logic               s1_fire;

	// handshake and stage movement
	assign out_adv        = !out_valid_q || writes.ready;
	assign s1_fire        = valid_s1 && (!has_result || out_adv);
	assign triplets.ready = !valid_s1 || s1_fire;

	// decode of the item held in the input register
	always_comb begin
		logic [SynW-1:0]  syn;
		logic [DataW-1:0] dec;
		logic [RowW-1:0]  row_base;
		logic             stop_base;
		logic             diac_mode;
		syn       = tx26_syndrome(raw_s1);
		dec       = tx26_extract(raw_s1, syn);
		addr      = dec[5:0];
		mode      = dec[10:6];
		code      = dec[17:11];
		row_base  = start_s1 ? '0 : active_row_q;
		stop_base = start_s1 ? 1'b0 : stopped_q;
		diac_mode = (mode >= ModeDiacFirst) && (mode <= ModeDiacLast);

		has_result   = 1'b0;
		row_next     = row_base;
		stopped_next = stop_base;
		if (!stop_base && !tx26_uncorrectable(syn)) begin
			if (addr >= RowGroupFirst) begin
				// row group: set active position or termination
				if (mode == ModeSetActive) begin
					row_next = (addr == RowGroupFirst) ? LastRow
						: RowW'(addr - RowGroupFirst);
				end else if (diac_mode) begin
					stopped_next = 1'b1;
				end
			end else begin
				// column group: character writes
				if (mode == ModeG2Char) begin
					has_result = (code >= G2CodeMin);
				end else if (diac_mode) begin
					has_result = 1'b1;
				end
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (triplets.ready) begin
			valid_s1 <= triplets.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (triplets.ready && triplets.valid) begin
			raw_s1   <= triplets.triplet_raw;
			start_s1 <= triplets.packet_start;
		end
	end

	// row and stop state, updated as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_row_q <= '0;
			stopped_q    <= 1'b0;
		end else if (s1_fire) begin
			active_row_q <= row_next;
			stopped_q    <= stopped_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s1_fire && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && s1_fire && has_result) begin
			char_row_q    <= row_next;
			char_column_q <= addr;
			char_code_q   <= code;
			if (mode == ModeG2Char) begin
				char_kind_q <= KindG2;
				diacritic_q <= '0;
			end else begin
				char_kind_q <= KindDiac;
				diacritic_q <= DiacW'(mode - ModeDiacFirst);
			end
		end
	end

	assign writes.valid       = out_valid_q;
	assign writes.char_row    = char_row_q;
	assign writes.char_column = char_column_q;
	assign writes.char_code   = char_code_q;
	assign writes.char_kind   = char_kind_q;
	assign writes.diacritic   = diacritic_q;

	// checks on decoder behaviour
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_row_q <= LastRow)
		else $error("active row out of range");

	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && stopped_q && !start_s1) |-> !has_result)
		else $error("write produced while stopped");

	a_g2_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (char_kind_q == KindG2)) |->
		(diacritic_q == '0) && (char_code_q >= G2CodeMin))
		else $error("bad G2 write fields");

	a_column_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (char_column_q < RowGroupFirst))
		else $error("write column in row group");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!triplets.ready |-> (valid_s1 && has_result && out_valid_q && !writes.ready))
		else $error("input stalled without a blocked write");

endmodule
